// ----- hdl/assert_macros.svh -----
// Assertion macros used by the module that checks its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/mme_pkg.sv -----
// Shared constants and types of the Montgomery modular exponentiation block.
`default_nettype none

package mme_pkg;

  // Width of the operand and result ports.
  localparam int DATA_WIDTH = 32;

  // Default width of the internal datapath.
  localparam int OPERAND_WIDTH_DEF = 32;

  // Operations of the shared arithmetic unit.
  typedef enum logic [1:0] {
    ALU_MONT,  // one Montgomery step: add multiplicand, add modulus if odd, halve
    ALU_DBL,   // one reduction step: shift in a bit, subtract modulus if needed
    ALU_FIX    // final conditional subtract of a Montgomery product
  } alu_op_t;

  // Control word that the sequencer hands to the arithmetic unit.
  typedef struct packed {
    alu_op_t op;
    logic    mult_bit;  // current multiplier bit for a Montgomery step
    logic    shift_bit; // bit shifted in by a reduction step
  } alu_ctrl_t;

endpackage

`default_nettype wire

// ----- hdl/mme_alu.sv -----
// Shared arithmetic unit: Montgomery step, modular doubling step and final subtract.
`default_nettype none

module mme_alu #(
  parameter int OPERAND_WIDTH = mme_pkg::OPERAND_WIDTH_DEF
) (
  input  wire mme_pkg::alu_ctrl_t   ctrl,
  input  wire [OPERAND_WIDTH:0]     acc,
  input  wire [OPERAND_WIDTH-1:0]   multiplicand,
  input  wire [OPERAND_WIDTH-1:0]   modulus,
  output logic [OPERAND_WIDTH:0]    result
);

  localparam int W = OPERAND_WIDTH;

  logic [W+1:0] sum_b;
  logic [W+1:0] sum_m;
  logic [W:0]   cmp_val;
  logic [W:0]   mod_ext;

  // The accumulator stays below twice the modulus, so W+2 bits hold every sum.
  always_comb begin
    sum_b   = {1'b0, acc} + (ctrl.mult_bit ? {2'b00, multiplicand} : '0);
    sum_m   = sum_b + (sum_b[0] ? {2'b00, modulus} : '0);
    mod_ext = {1'b0, modulus};
    if (ctrl.op == mme_pkg::ALU_DBL) begin
      cmp_val = {acc[W-1:0], ctrl.shift_bit};
    end else begin
      cmp_val = acc;
    end
    case (ctrl.op)
      mme_pkg::ALU_MONT: result = sum_m[W+1:1];
      mme_pkg::ALU_DBL,
      mme_pkg::ALU_FIX:  result = (cmp_val >= mod_ext) ? (cmp_val - mod_ext) : cmp_val;
      default:           result = acc;
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/montgomery_modular_exponent.sv -----
// Top level of the Montgomery modular exponentiation block with its sequencer.
`default_nettype none

// This block computes base_value ** exponent_value mod modulus_value, one item at a
// time, with a single shared arithmetic unit under a small sequencer. The operands are
// cut or zero-extended to OPERAND_WIDTH bits. The base and the value one are brought
// into the Montgomery domain (R = 2**OPERAND_WIDTH) by 2*OPERAND_WIDTH modular
// shift-and-subtract steps each, which reduce the operand and scale it by R in one
// pass. The exponent is then scanned from its most significant bit down: every bit
// costs one Montgomery squaring, and a set bit one more Montgomery product. Each product
// is OPERAND_WIDTH bit-serial steps followed by the final conditional subtract.
// A last product with one maps the result back out of the domain. The shared unit
// is busy one step per cycle while an item is computed. An even or zero modulus is
// answered on the next cycle with bad_modulus set and a zero result. The block holds
// in_stall high from the input transfer until its result transfer has completed, and
// takes no new item meanwhile. The result waits in output registers while out_stall
// is high.

module montgomery_modular_exponent #(
  parameter int OPERAND_WIDTH = mme_pkg::OPERAND_WIDTH_DEF
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire [mme_pkg::DATA_WIDTH-1:0]  base_value,
  input  wire [mme_pkg::DATA_WIDTH-1:0]  exponent_value,
  input  wire [mme_pkg::DATA_WIDTH-1:0]  modulus_value,
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic [mme_pkg::DATA_WIDTH-1:0] power_result,
  output logic                           bad_modulus
);

  localparam int W  = OPERAND_WIDTH;
  localparam int DW = mme_pkg::DATA_WIDTH;
  // Common width for moving between the ports and the datapath.
  localparam int XW = (W > DW) ? W : DW;
  // Step counter covers the 2W reduction steps.
  localparam int CW = $clog2(2 * W + 1);
  // Exponent bit counter holds W itself.
  localparam int EW = $clog2(W + 1);

  typedef enum logic [2:0] {
    S_IDLE,  // waiting for an input transfer
    S_REDA,  // base into the Montgomery domain
    S_REDX,  // one into the Montgomery domain
    S_SQR,   // squaring of the accumulator
    S_MUL,   // accumulator times base
    S_OUT,   // product with one, back out of the domain
    S_DONE   // result waits for its transfer
  } state_t;

  state_t            state;
  logic [CW-1:0]     cnt;
  logic [EW-1:0]     ecnt;
  logic [W:0]        acc;
  logic [W-1:0]      src;
  logic [W-1:0]      mplier;
  logic [W-1:0]      x_dom;
  logic [W-1:0]      a_dom;
  logic [W-1:0]      mod_r;
  logic [W-1:0]      exp_r;

  logic [XW-1:0]     base_ext;
  logic [XW-1:0]     exp_ext;
  logic [XW-1:0]     mod_ext;
  logic [XW-1:0]     res_ext;
  logic              in_xfer;
  logic              last_red;
  logic              fix_cycle;

  mme_pkg::alu_ctrl_t ctrl;
  logic [W-1:0]       alu_b;
  logic [W:0]         alu_res;

  // Operands are cut to the datapath width, or zero-extended when it is wider.
  assign base_ext = XW'(base_value);
  assign exp_ext  = XW'(exponent_value);
  assign mod_ext  = XW'(modulus_value);
  assign res_ext  = XW'(alu_res[W-1:0]);

  assign in_stall  = (state != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign last_red  = (cnt == CW'(2 * W - 1));
  assign fix_cycle = (cnt == CW'(W));

  // Control of the shared unit follows the sequencer state.
  always_comb begin
    ctrl.mult_bit  = mplier[0];
    ctrl.shift_bit = src[W-1];
    case (state)
      S_REDA, S_REDX: ctrl.op = mme_pkg::ALU_DBL;
      default:        ctrl.op = fix_cycle ? mme_pkg::ALU_FIX : mme_pkg::ALU_MONT;
    endcase
    case (state)
      S_MUL:   alu_b = a_dom;
      S_OUT:   alu_b = W'(1);
      default: alu_b = x_dom;
    endcase
  end

  mme_alu #(
    .OPERAND_WIDTH(W)
  ) u_alu (
    .ctrl         (ctrl),
    .acc          (acc),
    .multiplicand (alu_b),
    .modulus      (mod_r),
    .result       (alu_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      bad_modulus <= 1'b0;
      cnt         <= '0;
      ecnt        <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            mod_r <= mod_ext[W-1:0];
            exp_r <= exp_ext[W-1:0];
            src   <= base_ext[W-1:0];
            acc   <= '0;
            cnt   <= '0;
            if (!modulus_value[0]) begin
              // Even or zero modulus: answer at once with the error flag.
              power_result <= '0;
              bad_modulus  <= 1'b1;
              out_valid    <= 1'b1;
              state        <= S_DONE;
            end else begin
              state <= S_REDA;
            end
          end
        end
        S_REDA, S_REDX: begin
          // The operand bits go in first, then W zeros scale the remainder by R.
          if (last_red) begin
            acc <= '0;
            cnt <= '0;
            if (state == S_REDA) begin
              a_dom <= alu_res[W-1:0];
              src   <= W'(1);
              state <= S_REDX;
            end else begin
              x_dom  <= alu_res[W-1:0];
              mplier <= alu_res[W-1:0];
              ecnt   <= EW'(W);
              state  <= S_SQR;
            end
          end else begin
            acc <= alu_res;
            src <= src << 1;
            cnt <= cnt + CW'(1);
          end
        end
        S_SQR, S_MUL, S_OUT: begin
          if (!fix_cycle) begin
            acc    <= alu_res;
            mplier <= mplier >> 1;
            cnt    <= cnt + CW'(1);
          end else begin
            acc    <= '0;
            cnt    <= '0;
            x_dom  <= alu_res[W-1:0];
            mplier <= alu_res[W-1:0];
            if (state == S_OUT) begin
              power_result <= res_ext[DW-1:0];
              bad_modulus  <= 1'b0;
              out_valid    <= 1'b1;
              state        <= S_DONE;
            end else if (state == S_SQR && exp_r[W-1]) begin
              state <= S_MUL;
            end else begin
              // This exponent bit is done; move to the next one or finish.
              exp_r <= exp_r << 1;
              ecnt  <= ecnt - EW'(1);
              state <= (ecnt == EW'(1)) ? S_OUT : S_SQR;
            end
          end
        end
        S_DONE: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          out_valid <= 1'b0;
          state     <= S_IDLE;
        end
      endcase
    end
  end

`include "assert_macros.svh"

  // A waiting result keeps the input side closed.
  `ASSERT_IMPL(a_busy_while_result, out_valid, in_stall, "result shown while input is open")
  // An error result always carries a zero value.
  `ASSERT_IMPL(a_error_zero, out_valid && bad_modulus, power_result == '0,
               "error result with nonzero value")
  // An even modulus is flagged on the next cycle.
  `ASSERT_NEXT(a_even_flagged, in_valid && !in_stall && !modulus_value[0],
               out_valid && bad_modulus, "even modulus not flagged")
  // An odd modulus never gives a result on the next cycle.
  `ASSERT_NEXT(a_odd_busy, in_valid && !in_stall && modulus_value[0], !out_valid,
               "odd modulus answered too early")

endmodule

`default_nettype wire

// ----- test/montgomery_modular_exponent_test.sv -----
// Self-checking testbench for the Montgomery modular exponentiation block.
`timescale 1ns / 100ps

module montgomery_modular_exponent_test;

  // Number of random operand sets after the directed ones.
  localparam int RANDOM_ITEMS = 250;
  // The budget covers the worst item, long stalls on both sides and the receiver hold-off,
  // then takes that several times over.
  localparam int CYCLE_LIMIT = 3_000_000;
  // Quiet time after the last result, long enough to expose any result the block makes up.
  localparam int DRAIN_CYCLES = 2400;
  // Length of the receiver hold-off that backs the block up.
  localparam int HOLDOFF_CYCLES = 3000;
  localparam int HOLDOFF_AT_RESULT = 30;

  typedef struct packed {
    logic [mme_pkg::DATA_WIDTH-1:0] base;
    logic [mme_pkg::DATA_WIDTH-1:0] exponent;
    logic [mme_pkg::DATA_WIDTH-1:0] modulus;
  } operands_t;

  typedef struct packed {
    logic [mme_pkg::DATA_WIDTH-1:0] power;
    logic                           bad_mod;
  } power_entry_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [mme_pkg::DATA_WIDTH-1:0] base_value = '0;
  logic [mme_pkg::DATA_WIDTH-1:0] exponent_value = '0;
  logic [mme_pkg::DATA_WIDTH-1:0] modulus_value = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [mme_pkg::DATA_WIDTH-1:0] power_result;
  logic                           bad_modulus;

  operands_t    operand_queue[$];
  power_entry_t pending_powers[$];

  int error_count = 0;
  int results_seen = 0;
  int items_sent = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int holdoff_left = 0;
  bit holdoff_done = 1'b0;
  int cycle_count = 0;

  montgomery_modular_exponent u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .base_value     (base_value),
    .exponent_value (exponent_value),
    .modulus_value  (modulus_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .power_result   (power_result),
    .bad_modulus    (bad_modulus)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Straight right-to-left square-and-multiply with 64-bit products. For an odd modulus
  // the Montgomery datapath yields the fully reduced power, so plain arithmetic predicts
  // it exactly. A modulus of one gives zero, since one reduces to zero up front. An even
  // or zero modulus is flagged and the power is forced to zero.
  function automatic power_entry_t predict_power(operands_t op);
    power_entry_t entry;
    logic [63:0]  mod64;
    logic [63:0]  acc;
    logic [63:0]  square;
    mod64 = {32'd0, op.modulus};
    if (!op.modulus[0]) begin
      entry.power = '0;
      entry.bad_mod = 1'b1;
      return entry;
    end
    acc = 64'd1 % mod64;
    square = {32'd0, op.base} % mod64;
    for (int i = 0; i < mme_pkg::DATA_WIDTH; i++) begin
      if (op.exponent[i])
        acc = (acc * square) % mod64;
      square = (square * square) % mod64;
    end
    entry.power = acc[mme_pkg::DATA_WIDTH-1:0];
    entry.bad_mod = 1'b0;
    return entry;
  endfunction

  // Idle length: mostly none or a few cycles, now and then a long one.
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 88)
      return $urandom_range(1, 3);
    if (r < 97)
      return $urandom_range(4, 24);
    return $urandom_range(60, 200);
  endfunction

  function automatic logic [mme_pkg::DATA_WIDTH-1:0] pick_value(bit allow_small);
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)
      return '0;
    if (r < 16)
      return '1;
    if (allow_small && r < 30)
      return $urandom_range(1, 40);
    return $urandom();
  endfunction

  task automatic queue_item(logic [mme_pkg::DATA_WIDTH-1:0] b,
                            logic [mme_pkg::DATA_WIDTH-1:0] e,
                            logic [mme_pkg::DATA_WIDTH-1:0] m);
    operands_t op;
    op.base = b;
    op.exponent = e;
    op.modulus = m;
    operand_queue.push_back(op);
  endtask

  // Sender. A held transfer keeps its payload; after a transfer or while idle the next
  // operand set goes out once the current gap has run down. Items 60 to 99 go out
  // back to back so that the input side also sees a stretch with no idling.
  always @(posedge clk) begin : drive_operands
    operands_t op;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        pending_powers.push_back(predict_power({base_value, exponent_value, modulus_value}));
        items_sent++;
        send_gap = (items_sent >= 60 && items_sent < 100) ? 0 : idle_cycles();
      end
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (operand_queue.size() != 0) begin
          op = operand_queue.pop_front();
          base_value <= op.base;
          exponent_value <= op.exponent;
          modulus_value <= op.modulus;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Once, after a few dozen results, the receiver stops taking results for a long
  // stretch. The sender keeps offering, so the block sits on a finished result and must
  // hold its input stalled the whole time.
  always @(posedge clk) begin
    if (!rst && !holdoff_done && results_seen == HOLDOFF_AT_RESULT) begin
      holdoff_left <= HOLDOFF_CYCLES;
      holdoff_done <= 1'b1;
    end else if (holdoff_left > 0) begin
      holdoff_left <= holdoff_left - 1;
    end
  end

  // Receiver and checker. Every result transfer is matched against the oldest
  // prediction. Stall gaps are drawn continually so they land on every phase of the
  // computation; while 150 to 189 results have been seen, no new gap is drawn.
  always @(posedge clk) begin : check_results
    power_entry_t want;
    bit           quiet;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (pending_powers.size() == 0) begin
          $display("%0t: result with none expected: power_result=%h bad_modulus=%b",
                   $time, power_result, bad_modulus);
          error_count++;
        end else begin
          want = pending_powers.pop_front();
          if (power_result !== want.power) begin
            $display("%0t: power_result expected %h actual %h",
                     $time, want.power, power_result);
            error_count++;
          end
          if (bad_modulus !== want.bad_mod) begin
            $display("%0t: bad_modulus expected %b actual %b",
                     $time, want.bad_mod, bad_modulus);
            error_count++;
          end
        end
      end
      quiet = results_seen >= 150 && results_seen < 190;
      if (recv_gap > 0)
        recv_gap--;
      else if (!quiet && $urandom_range(0, 3) == 0)
        recv_gap = idle_cycles();
      out_stall <= (holdoff_left != 0) || (recv_gap != 0);
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    logic [mme_pkg::DATA_WIDTH-1:0] m;
    int                             r;

    // Directed operand sets: modulus one, zero and even moduli, the all-ones extremes,
    // zero base and exponent, a base at or above the modulus, and known answers.
    queue_item(32'd0, 32'd0, 32'd1);
    queue_item(32'd5, 32'd3, 32'd1);
    queue_item(32'd0, 32'd0, 32'hFFFF_FFFF);
    queue_item(32'd0, 32'd5, 32'd13);
    queue_item(32'd7, 32'd0, 32'd13);
    queue_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFB);
    queue_item(32'd2, 32'd10, 32'd1001);
    queue_item(32'd4, 32'd13, 32'd497);
    queue_item(32'd13, 32'd12, 32'd13);
    queue_item(32'd100, 32'd1, 32'd7);
    queue_item(32'd12345, 32'd1, 32'd0);
    queue_item(32'd3, 32'd4, 32'd2);
    queue_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
    queue_item(32'd3, 32'hFFFF_FFFA, 32'hFFFF_FFFB);
    queue_item(32'hFFFF_FFFE, 32'd2, 32'hFFFF_FFFF);
    queue_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0001);
    queue_item(32'd2, 32'd31, 32'd3);
    queue_item(32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    queue_item(32'h1234_5678, 32'h8000_0000, 32'd0);

    // Random operand sets. Most carry an odd modulus so that the full exponentiation
    // runs; a small share have an even or zero modulus, and some use small moduli where
    // the base often exceeds the modulus.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 9)
        m = (r < 2) ? '0 : ($urandom() & ~32'd1);
      else if (r < 25)
        m = $urandom_range(1, 255) | 32'd1;
      else
        m = $urandom() | 32'd1;
      queue_item(pick_value(1'b1), pick_value(1'b1), m);
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Checked away from the rising edge, once the driver and checker have settled.
    do
      @(negedge clk);
    while (operand_queue.size() != 0 || in_valid || pending_powers.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pending_powers.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_powers.size());
      error_count++;
    end
    if (error_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ----- montgomery_modular_exponent.f -----
+incdir+hdl
hdl/mme_pkg.sv
hdl/mme_alu.sv
hdl/montgomery_modular_exponent.sv
test/montgomery_modular_exponent_test.sv
